// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the line edit queue RTL. Define NO_ASSERTIONS to
// compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/lnq_pkg.sv
// ----------------------------------------------------------------------------
// lnq_pkg
// Types and codes shared by the line edit queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lnq_pkg;

    // fixed widths of the result word fields
    localparam int LEN_OUT_W  = 7;
    localparam int WAIT_OUT_W = 4;

    // character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // input selector
    localparam logic FUNC_CHAR = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // refusal causes
    localparam logic CAUSE_EMPTY = 1'b0;
    localparam logic CAUSE_SMALL = 1'b1;

    typedef enum logic [2:0] {
        K_ECHO_CHAR    = 3'd0,
        K_ECHO_ERASE   = 3'd1,
        K_LINE_BYTE    = 3'd2,
        K_POP_REFUSED  = 3'd3,
        K_LINE_DROPPED = 3'd4,
        K_CHAR_DROPPED = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_ECHO_LF,
        S_DROP_LINE,
        S_COPY,
        S_COPY_LF,
        S_POP_CHK,
        S_POP_STREAM
    } t_state;

    typedef struct packed {
        t_kind                   kind;
        logic [7:0]              data_byte;
        logic [LEN_OUT_W-1:0]    line_len;
        logic                    refuse_cause;
        logic                    last;
        logic [WAIT_OUT_W-1:0]   lines_waiting;
    } t_res;

endpackage

`default_nettype wire

// File: src/line_edit_queue.sv
// ----------------------------------------------------------------------------
// line_edit_queue
// Canonical line editor with echo, feeding a ring of completed lines that a
// reader pops one line at a time.
//
//   channel  dir  words                  payload
//   s_axis   in   one per item           tuser func, tdata char_in, rd_cap
//   m_axis   out  0..MAX_LINE per item   tuser kind, tlast, tdata fields
//
// A printable character or an erase of a non-empty line is accepted, then its echo
// word (or a drop word when the line is full) is emitted; any other character ends at the accept.
// A line end passes through accept, the echo, a copy of each pending byte, then the
// newline and length write; when the ring is full, a drop word follows the echo instead.
// A pop passes through the length lookup and check, then streams one line byte per
// cycle from the line store read port while m_axis has space, or emits a refusal word.
// Reset clears the control state only; line RAMs are not cleared.
// A stalled m_axis holds the sequencer; s_axis is ready only between items.
// ----------------------------------------------------------------------------
`default_nettype none

module line_edit_queue
    import lnq_pkg::*;
#(
    parameter int MAX_LINE   = 64,
    parameter int RING_LINES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,  // char_in[7:0], rd_cap[23:8]
    input  wire logic        i_s_axis_tuser,  // func[0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [23:0] o_m_axis_tdata,  // data_byte[7:0], line_len[14:8],
                                              // refuse_cause[15], lines_waiting[19:16],
                                              // zero[23:20]
    output logic       [2:0] o_m_axis_tuser,  // kind[2:0]
    output logic             o_m_axis_tlast
);

    logic c_push, c_space;
    t_res c_res, q_res;

    lnq_ctrl #(
        .MAX_LINE   (MAX_LINE),
        .RING_LINES (RING_LINES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_func  (i_s_axis_tuser),
        .i_char  (i_s_axis_tdata[7:0]),
        .i_size  (i_s_axis_tdata[23:8]),
        .o_push  (c_push),
        .o_res   (c_res),
        .i_space (c_space)
    );

    lnq_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_push),
        .i_res   (c_res),
        .o_space (c_space),
        .o_valid (o_m_axis_tvalid),
        .o_res   (q_res),
        .i_ready (i_m_axis_tready)
    );

    // pack the result word
    assign o_m_axis_tdata = {4'b0000, q_res.lines_waiting, q_res.refuse_cause,
                             q_res.line_len, q_res.data_byte};
    assign o_m_axis_tuser = q_res.kind;
    assign o_m_axis_tlast = q_res.last;

endmodule

`default_nettype wire

// File: src/lnq_ram.sv
// ----------------------------------------------------------------------------
// lnq_ram
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data (holds while not read).
// ----------------------------------------------------------------------------
`default_nettype none

module lnq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data registered
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: src/lnq_ctrl.sv
// ----------------------------------------------------------------------------
// lnq_ctrl
// Sequencer of the line editor: edits the pending line held in its own RAM,
// copies completed lines into the line store ring and streams them out.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lnq_ctrl
    import lnq_pkg::*;
#(
    parameter int MAX_LINE   = 64,
    parameter int RING_LINES = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input word
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_func,
    input  wire logic [7:0]  i_char,
    input  wire logic [15:0] i_size,
    // result word toward the output register
    output logic             o_push,
    output t_res             o_res,
    input  wire logic        i_space
);

    localparam int PA_W  = $clog2(MAX_LINE);
    localparam int L_W   = $clog2(MAX_LINE + 1);
    localparam int RA_W  = (RING_LINES > 1) ? $clog2(RING_LINES) : 1;
    localparam int CNT_W = $clog2(RING_LINES + 1);
    localparam int SA_W  = (RING_LINES * MAX_LINE > 1) ? $clog2(RING_LINES * MAX_LINE) : 1;

    t_state r_state, n_state;

    logic [PA_W-1:0]  r_plen;
    logic [RA_W-1:0]  r_head, r_tail;
    logic [CNT_W-1:0] r_count;
    logic [L_W-1:0]   r_idx;
    logic [L_W-1:0]   r_len;
    logic             r_wv;
    logic [PA_W-1:0]  r_widx;
    logic [15:0]      r_size;
    t_res             r_res, n_res;

    // memory ports
    logic             pend_wr_en, pend_rd_en;
    logic [7:0]       pend_rd_data;
    logic             line_wr_en, line_rd_en;
    logic [SA_W-1:0]  line_wr_addr, line_rd_addr;
    logic [7:0]       line_wr_data, line_rd_data;
    logic             len_wr_en, len_rd_en;
    logic [L_W-1:0]   len_rd_data;

    // decode
    logic             w_acc, w_lf, w_erase, w_print;
    logic             w_line_full, w_ring_full, w_len_fail, w_pop_last;
    logic [L_W-1:0]   w_plen_ext, w_rd_off;
    logic [31:0]      w_cnt_now, w_cnt_up, w_cnt_dn;
    logic [31:0]      w_tail_base, w_head_base, w_wr_off;
    logic [RA_W-1:0]  w_head_nx, w_tail_nx;

    assign w_acc       = i_valid && (r_state == S_IDLE);
    assign w_lf        = (i_char == CH_CR) || (i_char == CH_LF);
    assign w_erase     = (i_char == CH_DEL) || (i_char == CH_BS);
    assign w_print     = (i_char >= CH_SPACE) && (i_char <= CH_TILDE);
    assign w_line_full = (r_plen == PA_W'(MAX_LINE - 1));
    assign w_ring_full = (r_count == CNT_W'(RING_LINES));
    assign w_len_fail  = (16'(len_rd_data) > r_size);
    assign w_pop_last  = (r_idx == (r_len - L_W'(1)));
    assign w_plen_ext  = L_W'(r_plen);

    assign w_cnt_now = 32'(r_count);
    assign w_cnt_up  = w_cnt_now + 32'd1;
    assign w_cnt_dn  = w_cnt_now - 32'd1;

    assign w_head_nx = (r_head == RA_W'(RING_LINES - 1)) ? '0 : r_head + RA_W'(1);
    assign w_tail_nx = (r_tail == RA_W'(RING_LINES - 1)) ? '0 : r_tail + RA_W'(1);

    // line store addresses: slot base plus byte offset
    assign w_tail_base = 32'(r_tail) * MAX_LINE;
    assign w_head_base = 32'(r_head) * MAX_LINE;
    assign w_wr_off    = (r_state == S_COPY_LF) ? 32'(r_plen) : 32'(r_widx);
    assign w_rd_off    = (r_state == S_POP_CHK) ? '0 : r_idx + L_W'(1);
    assign line_wr_addr = SA_W'(w_tail_base + w_wr_off);
    assign line_rd_addr = SA_W'(w_head_base + 32'(w_rd_off));
    assign line_wr_data = (r_state == S_COPY_LF) ? CH_LF : pend_rd_data;

    lnq_ram #(.DEPTH(MAX_LINE), .WIDTH(8), .AW(PA_W)) u_pend_ram (
        .i_clk     (i_clk),
        .i_wr_en   (pend_wr_en),
        .i_wr_addr (r_plen),
        .i_wr_data (i_char),
        .i_rd_en   (pend_rd_en),
        .i_rd_addr (r_idx[PA_W-1:0]),
        .o_rd_data (pend_rd_data)
    );

    lnq_ram #(.DEPTH(RING_LINES * MAX_LINE), .WIDTH(8), .AW(SA_W)) u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (line_wr_en),
        .i_wr_addr (line_wr_addr),
        .i_wr_data (line_wr_data),
        .i_rd_en   (line_rd_en),
        .i_rd_addr (line_rd_addr),
        .o_rd_data (line_rd_data)
    );

    lnq_ram #(.DEPTH(RING_LINES), .WIDTH(L_W), .AW(RA_W)) u_len_ram (
        .i_clk     (i_clk),
        .i_wr_en   (len_wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data (w_plen_ext + L_W'(1)),
        .i_rd_en   (len_rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (len_rd_data)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    if (i_func == FUNC_POP) begin
                        n_state = S_POP_CHK;
                    end else if (w_lf) begin
                        n_state = S_ECHO_LF;
                    end else if ((w_erase && (r_plen != '0)) || w_print) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_space) n_state = S_IDLE;
            end
            S_ECHO_LF: begin
                if (i_space) n_state = w_ring_full ? S_DROP_LINE : S_COPY;
            end
            S_DROP_LINE: begin
                if (i_space) n_state = S_IDLE;
            end
            S_COPY: begin
                if (r_idx == w_plen_ext) n_state = S_COPY_LF;
            end
            S_COPY_LF: begin
                n_state = S_IDLE;
            end
            S_POP_CHK: begin
                if ((r_size == '0) || (r_count == '0) || w_len_fail) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_POP_STREAM;
                end
            end
            S_POP_STREAM: begin
                if (i_space && w_pop_last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and memory strobes
    always_comb begin
        o_ready             = (r_state == S_IDLE);
        o_push              = 1'b0;
        o_res               = '0;
        o_res.lines_waiting = w_cnt_now[WAIT_OUT_W-1:0];
        pend_wr_en          = 1'b0;
        pend_rd_en          = 1'b0;
        line_wr_en          = r_wv;
        line_rd_en          = 1'b0;
        len_wr_en           = 1'b0;
        len_rd_en           = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                pend_wr_en = w_acc && (i_func == FUNC_CHAR) && !w_lf && !w_erase
                             && w_print && !w_line_full;
                len_rd_en  = w_acc && (i_func == FUNC_POP);
            end
            S_EMIT: begin
                o_push = i_space;
                o_res  = r_res;
            end
            S_ECHO_LF: begin
                o_push          = i_space;
                o_res.kind      = K_ECHO_CHAR;
                o_res.data_byte = CH_LF;
                o_res.last      = !w_ring_full;
                if (!w_ring_full) o_res.lines_waiting = w_cnt_up[WAIT_OUT_W-1:0];
            end
            S_DROP_LINE: begin
                o_push     = i_space;
                o_res.kind = K_LINE_DROPPED;
                o_res.last = 1'b1;
            end
            S_COPY: begin
                pend_rd_en = (r_idx < w_plen_ext);
            end
            S_COPY_LF: begin
                line_wr_en = 1'b1;
                len_wr_en  = 1'b1;
            end
            S_POP_CHK: begin
                line_rd_en = !((r_size == '0) || (r_count == '0) || w_len_fail);
            end
            S_POP_STREAM: begin
                o_push              = i_space;
                o_res.kind          = K_LINE_BYTE;
                o_res.data_byte     = line_rd_data;
                o_res.line_len      = LEN_OUT_W'(r_len);
                o_res.last          = w_pop_last;
                o_res.lines_waiting = w_cnt_dn[WAIT_OUT_W-1:0];
                line_rd_en          = i_space && !w_pop_last;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // line and ring bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen  <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_wv    <= 1'b0;
        end else begin
            r_wv <= (r_state == S_COPY) && pend_rd_en;
            unique case (r_state)
                S_IDLE: begin
                    if (w_acc && (i_func == FUNC_CHAR)) begin
                        if (w_lf) begin
                            r_idx <= '0;
                        end else if (w_erase) begin
                            if (r_plen != '0) r_plen <= r_plen - PA_W'(1);
                        end else if (pend_wr_en) begin
                            r_plen <= r_plen + PA_W'(1);
                        end
                    end
                end
                S_DROP_LINE: begin
                    if (i_space) r_plen <= '0;
                end
                S_COPY: begin
                    if (pend_rd_en) r_idx <= r_idx + L_W'(1);
                end
                S_COPY_LF: begin
                    r_tail  <= w_tail_nx;
                    r_count <= r_count + CNT_W'(1);
                    r_plen  <= '0;
                end
                S_POP_CHK: begin
                    r_idx <= '0;
                end
                S_POP_STREAM: begin
                    if (i_space) begin
                        if (w_pop_last) begin
                            r_head  <= w_head_nx;
                            r_count <= r_count - CNT_W'(1);
                        end else begin
                            r_idx <= r_idx + L_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // next pending result: load on a character accept or at the pop check
    always_comb begin
        n_res = r_res;
        if (w_acc && (i_func == FUNC_CHAR)) begin
            n_res               = '0;
            n_res.last          = 1'b1;
            n_res.lines_waiting = w_cnt_now[WAIT_OUT_W-1:0];
            if (w_erase) begin
                n_res.kind = K_ECHO_ERASE;
            end else if (w_line_full) begin
                n_res.kind = K_CHAR_DROPPED;
            end else begin
                n_res.kind      = K_ECHO_CHAR;
                n_res.data_byte = i_char;
            end
        end else if (r_state == S_POP_CHK) begin
            n_res               = '0;
            n_res.kind          = K_POP_REFUSED;
            n_res.last          = 1'b1;
            n_res.lines_waiting = w_cnt_now[WAIT_OUT_W-1:0];
            n_res.refuse_cause  = ((r_size == '0) || (r_count == '0)) ? CAUSE_EMPTY
                                                                     : CAUSE_SMALL;
        end
    end

    // payload registers: copy index, pop size and length, pending result
    always_ff @(posedge i_clk) begin
        r_widx <= r_idx[PA_W-1:0];
        if (w_acc) r_size <= i_size;
        if (r_state == S_POP_CHK) r_len <= len_rd_data;
        r_res <= n_res;
    end

    // checks
    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(RING_LINES),
                "ring count overflow")
    `ASSERT_CLK(a_plen_bound, i_clk, i_rst_n, 32'(r_plen) < MAX_LINE,
                "pending line overflow")
    `ASSERT_CLK(a_ring_ptrs, i_clk, i_rst_n,
                (r_head == r_tail) == ((r_count == '0) || w_ring_full),
                "ring pointers disagree with count")
    `ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, o_push && o_res.last,
                 (r_state == S_IDLE) || (r_state == S_COPY),
                 "last word did not end the item")

endmodule

`default_nettype wire

// File: src/lnq_out_reg.sv
// ----------------------------------------------------------------------------
// lnq_out_reg
// Output register of the result stream: holds one word until the sink takes
// it and accepts a new word in the same cycle the old one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module lnq_out_reg
    import lnq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_res      i_res,
    output logic      o_space,
    output logic      o_valid,
    output t_res      o_res,
    input  wire logic i_ready
);

    logic r_valid;
    t_res r_res;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // load on push, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_res <= i_res;
    end

endmodule

`default_nettype wire

// File: test/line_edit_queue_tb.sv
// ----------------------------------------------------------------------------
// line_edit_queue_tb
// Self-checking bench for the line edit queue. Stimulus drives characters and
// pop requests on s_axis. A behavioral copy of the editor and the line ring
// predicts the m_axis words, typed table rows bring their own, and each
// word is checked field by field in order. The run starts with a table of
// directed items, then follows with scripted phases: a long receiver stall,
// a ring overflow and an overlong line. After that comes a random mix of
// edited lines, pops and noise. Both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module line_edit_queue_tb;
    import lnq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LINE    = 64;
    localparam int RING_LINES  = 8;
    localparam int LIVE_ITEMS  = 330;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 80;

    // one row of the directed table; typed rows carry their expected word, if any
    typedef struct {
        logic       func;
        logic [7:0] ch;
        logic [15:0] size;
        bit         typed;
        int         n_words;
        t_kind      kind;
        logic [7:0] data_byte;
        logic       cause;
        logic [3:0] lines;
    } t_row;

    logic        i_clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;   // char_in[7:0], rd_cap[23:8]
    logic        s_tuser  = 1'b0; // func[0]
    logic        m_tready = 1'b0;
    logic        steady   = 1'b0;
    int          hold_reqs = 0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;  // data_byte[7:0], line_len[14:8],
                                  // refuse_cause[15], lines_waiting[19:16]
    logic  [2:0] o_m_axis_tuser;  // kind[2:0]
    logic        o_m_axis_tlast;

    // editor and ring state as the block should hold it
    logic [7:0]  typed_line [MAX_LINE];
    int unsigned typed_len;
    logic [7:0]  line_slots [RING_LINES][MAX_LINE];
    int unsigned slot_len   [RING_LINES];
    int unsigned rd_slot, wr_slot, lines_held;

    t_res step_words [$];
    t_res owed_words [$];
    int   mismatches;
    int   live_count;
    t_row dir_rows [20];

    line_edit_queue #(
        .MAX_LINE   (MAX_LINE),
        .RING_LINES (RING_LINES)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // hard stop in case the block hangs
    initial begin
        #4_000_000;
        $display("line_edit_queue regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $realtime, what);
    endtask

    function automatic void add_word(t_kind k, logic [7:0] d, int unsigned len, logic cause);
        t_res w;
        w.kind          = k;
        w.data_byte     = d;
        w.line_len      = len[LEN_OUT_W-1:0];
        w.refuse_cause  = cause;
        w.last          = 1'b0;
        w.lines_waiting = '0;
        step_words.push_back(w);
    endfunction

    // advance the editor by one item and list the words it should emit
    function automatic void edit_step(logic func, logic [7:0] ch_in, logic [15:0] size);
        logic [7:0]  c;
        int unsigned ln;
        step_words.delete();
        if (func == FUNC_CHAR) begin
            c = ch_in;
            if (c == CH_CR)
                c = CH_LF;
            else if (c == CH_DEL)
                c = CH_BS;
            if (c == CH_BS) begin
                if (typed_len > 0) begin
                    typed_len--;
                    add_word(K_ECHO_ERASE, 8'h00, 0, 1'b0);
                end
            end else if (c == CH_LF) begin
                add_word(K_ECHO_CHAR, CH_LF, 0, 1'b0);
                if (lines_held >= RING_LINES) begin
                    add_word(K_LINE_DROPPED, 8'h00, 0, 1'b0);
                end else begin
                    for (int i = 0; i < typed_len; i++)
                        line_slots[wr_slot][i] = typed_line[i];
                    line_slots[wr_slot][typed_len] = CH_LF;
                    slot_len[wr_slot] = typed_len + 1;
                    wr_slot = (wr_slot + 1) % RING_LINES;
                    lines_held++;
                end
                typed_len = 0;
            end else if (c >= CH_SPACE && c <= CH_TILDE) begin
                if (typed_len + 1 >= MAX_LINE) begin
                    add_word(K_CHAR_DROPPED, 8'h00, 0, 1'b0);
                end else begin
                    typed_line[typed_len] = c;
                    typed_len++;
                    add_word(K_ECHO_CHAR, c, 0, 1'b0);
                end
            end
        end else begin
            if (size == 0 || lines_held == 0) begin
                add_word(K_POP_REFUSED, 8'h00, 0, CAUSE_EMPTY);
            end else begin
                ln = slot_len[rd_slot];
                if (ln > size) begin
                    add_word(K_POP_REFUSED, 8'h00, 0, CAUSE_SMALL);
                end else begin
                    for (int i = 0; i < ln; i++)
                        add_word(K_LINE_BYTE, line_slots[rd_slot][i], ln, 1'b0);
                    rd_slot = (rd_slot + 1) % RING_LINES;
                    lines_held--;
                end
            end
        end
        foreach (step_words[i]) begin
            step_words[i].lines_waiting = lines_held[WAIT_OUT_W-1:0];
            step_words[i].last          = (i == step_words.size() - 1);
        end
    endfunction

    // offer one word on s_axis, with an occasional random gap before it, and wait for accept
    task automatic send_item(input logic func, input logic [7:0] ch, input logic [15:0] size);
        if (!steady && $urandom_range(0, 99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {size, ch};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        live_count++;
    endtask

    task automatic run_item(input logic func, input logic [7:0] ch, input logic [15:0] size);
        send_item(func, ch, size);
        edit_step(func, ch, size);
        foreach (step_words[i])
            owed_words.push_back(step_words[i]);
    endtask

    function automatic logic [7:0] printable();
        return 8'($urandom_range(int'(CH_SPACE), int'(CH_TILDE)));
    endfunction

    function automatic logic [15:0] pop_size();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'($urandom_range(1, 8));
            2:       return 16'($urandom);
            3, 4, 5: return 16'($urandom_range(16, 80));
            default: return 16'hFFFF;
        endcase
    endfunction

    // type a line of n characters and end it; a noisy line mixes in erases,
    // stray bytes and pops
    task automatic type_line(input int n, input bit noisy);
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (noisy && r < 8)
                run_item(FUNC_CHAR, $urandom_range(0, 1) ? CH_BS : CH_DEL, 16'($urandom));
            else if (noisy && r < 12)
                run_item(FUNC_CHAR, $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                         : 8'($urandom_range(128, 255)),
                         16'($urandom));
            else if (noisy && r < 15)
                run_item(FUNC_POP, 8'($urandom), pop_size());
            else
                run_item(FUNC_CHAR, printable(), 16'($urandom));
        end
        run_item(FUNC_CHAR, $urandom_range(0, 1) ? CH_LF : CH_CR, 16'($urandom));
    endtask

    // drop valid and wait until every owed word has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (owed_words.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int seen_holds;
        seen_holds = 0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != seen_holds) begin
                seen_holds = hold_reqs;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 7);
        end
    end

    // check each accepted word against the oldest owed word
    always @(posedge i_clk) begin
        t_res want;
        if (rst_n && o_m_axis_tvalid && m_tready) begin
            if (owed_words.size() == 0) begin
                report_mismatch($sformatf("word kind %0d with nothing owed", o_m_axis_tuser));
            end else begin
                want = owed_words.pop_front();
                if (o_m_axis_tuser !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", o_m_axis_tuser, want.kind));
                if (o_m_axis_tdata[7:0] !== want.data_byte)
                    report_mismatch($sformatf("data_byte %0h, want %0h",
                                              o_m_axis_tdata[7:0], want.data_byte));
                if (o_m_axis_tdata[14:8] !== want.line_len)
                    report_mismatch($sformatf("line_len %0d, want %0d",
                                              o_m_axis_tdata[14:8], want.line_len));
                if (o_m_axis_tdata[15] !== want.refuse_cause)
                    report_mismatch($sformatf("refuse_cause %0b, want %0b",
                                              o_m_axis_tdata[15], want.refuse_cause));
                if (o_m_axis_tdata[19:16] !== want.lines_waiting)
                    report_mismatch($sformatf("lines_waiting %0d, want %0d",
                                              o_m_axis_tdata[19:16], want.lines_waiting));
                if (o_m_axis_tdata[23:20] !== 4'h0)
                    report_mismatch($sformatf("pad bits %0h", o_m_axis_tdata[23:20]));
                if (o_m_axis_tlast !== want.last)
                    report_mismatch($sformatf("tlast %0b, want %0b", o_m_axis_tlast, want.last));
            end
        end
    end

    initial begin
        t_res w;
        int   r;
        mismatches = 0;
        live_count = 0;
        typed_len  = 0;
        rd_slot    = 0;
        wr_slot    = 0;
        lines_held = 0;

        // directed items; characters carry all-ones or zero size bits to show they are ignored
        dir_rows = '{
            '{FUNC_POP,  8'h00,    16'h1234, 1, 1, K_POP_REFUSED, 8'h00,    CAUSE_EMPTY, 4'd0},
            '{FUNC_CHAR, CH_BS,    16'hFFFF, 1, 0, K_ECHO_CHAR,   8'h00,    1'b0,        4'd0},
            '{FUNC_CHAR, CH_DEL,   16'hFFFF, 1, 0, K_ECHO_CHAR,   8'h00,    1'b0,        4'd0},
            '{FUNC_CHAR, 8'h00,    16'hFFFF, 1, 0, K_ECHO_CHAR,   8'h00,    1'b0,        4'd0},
            '{FUNC_CHAR, 8'hFF,    16'hFFFF, 1, 0, K_ECHO_CHAR,   8'h00,    1'b0,        4'd0},
            '{FUNC_CHAR, 8'h80,    16'h0000, 1, 0, K_ECHO_CHAR,   8'h00,    1'b0,        4'd0},
            '{FUNC_CHAR, 8'h1F,    16'hFFFF, 1, 0, K_ECHO_CHAR,   8'h00,    1'b0,        4'd0},
            '{FUNC_CHAR, CH_SPACE, 16'hFFFF, 1, 1, K_ECHO_CHAR,   CH_SPACE, 1'b0,        4'd0},
            '{FUNC_CHAR, CH_TILDE, 16'hFFFF, 1, 1, K_ECHO_CHAR,   CH_TILDE, 1'b0,        4'd0},
            '{FUNC_CHAR, CH_DEL,   16'hFFFF, 1, 1, K_ECHO_ERASE,  8'h00,    1'b0,        4'd0},
            '{FUNC_CHAR, CH_CR,    16'hFFFF, 0, 0, K_ECHO_CHAR,   8'h00,    1'b0,        4'd0},
            '{FUNC_POP,  8'hFF,    16'h0000, 1, 1, K_POP_REFUSED, 8'h00,    CAUSE_EMPTY, 4'd1},
            '{FUNC_POP,  8'hFF,    16'h0001, 1, 1, K_POP_REFUSED, 8'h00,    CAUSE_SMALL, 4'd1},
            '{FUNC_POP,  8'hFF,    16'hFFFF, 0, 0, K_ECHO_CHAR,   8'h00,    1'b0,        4'd0},
            '{FUNC_POP,  8'h00,    16'hFFFF, 1, 1, K_POP_REFUSED, 8'h00,    CAUSE_EMPTY, 4'd0},
            '{FUNC_CHAR, 8'h41,    16'h0000, 1, 1, K_ECHO_CHAR,   8'h41,    1'b0,        4'd0},
            '{FUNC_CHAR, CH_LF,    16'h0000, 0, 0, K_ECHO_CHAR,   8'h00,    1'b0,        4'd0},
            '{FUNC_POP,  8'h00,    16'h0002, 0, 0, K_ECHO_CHAR,   8'h00,    1'b0,        4'd0},
            '{FUNC_CHAR, CH_LF,    16'hFFFF, 0, 0, K_ECHO_CHAR,   8'h00,    1'b0,        4'd0},
            '{FUNC_POP,  8'h00,    16'h0001, 0, 0, K_ECHO_CHAR,   8'h00,    1'b0,        4'd0}
        };

        // hold reset, then release it
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed table
        foreach (dir_rows[i]) begin
            if (dir_rows[i].typed) begin
                send_item(dir_rows[i].func, dir_rows[i].ch, dir_rows[i].size);
                edit_step(dir_rows[i].func, dir_rows[i].ch, dir_rows[i].size);
                if (dir_rows[i].n_words == 1) begin
                    w.kind          = dir_rows[i].kind;
                    w.data_byte     = dir_rows[i].data_byte;
                    w.line_len      = '0;
                    w.refuse_cause  = dir_rows[i].cause;
                    w.last          = 1'b1;
                    w.lines_waiting = dir_rows[i].lines;
                    owed_words.push_back(w);
                end
            end else begin
                run_item(dir_rows[i].func, dir_rows[i].ch, dir_rows[i].size);
            end
        end

        // stall the receiver while lines keep coming, so the input backs up
        hold_reqs++;
        type_line(12, 1'b0);
        type_line(6, 1'b0);
        run_item(FUNC_POP, 8'h00, 16'hFFFF);
        wait_drained();

        // overflow the ring with no idling on either side, then empty it
        steady <= 1'b1;
        for (int i = 0; i < RING_LINES + 2; i++)
            type_line($urandom_range(0, 5), 1'b0);
        for (int i = 0; i < RING_LINES + 1; i++)
            run_item(FUNC_POP, 8'($urandom), 16'hFFFF);
        steady <= 1'b0;
        wait_drained();

        // overlong line: drops at the full mark, then refuse one short of it
        type_line(MAX_LINE + 3, 1'b0);
        run_item(FUNC_POP, 8'h00, 16'(MAX_LINE - 1));
        run_item(FUNC_POP, 8'h00, 16'(MAX_LINE));

        // random mix of edited lines, pops and stray bytes
        while (live_count < LIVE_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                type_line(($urandom_range(0, 9) == 0) ? $urandom_range(40, 70)
                                                      : $urandom_range(0, 16), 1'b1);
            end else if (r < 75) begin
                run_item(FUNC_POP, 8'($urandom), pop_size());
            end else if (r < 80) begin
                repeat (lines_held + 1) run_item(FUNC_POP, 8'($urandom), 16'hFFFF);
            end else if (r < 90) begin
                run_item(1'($urandom), 8'($urandom), 16'($urandom));
            end else begin
                repeat ($urandom_range(1, 6))
                    run_item(FUNC_CHAR, $urandom_range(0, 1) ? CH_BS : CH_DEL, 16'($urandom));
            end
        end

        // let the last words drain
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0)
            $display("line_edit_queue regression: pass");
        else
            $display("line_edit_queue regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
